/* hw/rtl/rpr_pkg.sv */
// ----------------------------------------------------------------------------
// rpr_pkg
// Shared constants, types and helpers for the row prefix rectangle sum unit.
// ----------------------------------------------------------------------------
package rpr_pkg;

	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;

	localparam int DATA_W    = 32;
	localparam int COORD_W   = 6;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;

	localparam logic [CFG_W-1:0] NUM_ROWS_RST = 7'd64;
	localparam logic [CFG_W-1:0] NUM_COLS_RST = 7'd64;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef struct packed {
		logic [CFG_W-1:0] rows;
		logic [CFG_W-1:0] cols;
	} rpr_size_t;

	// zero counts as one, anything above the maximum counts as the maximum
	function automatic logic [CFG_W-1:0] eff_size(logic [CFG_W-1:0] v, int maxv);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (int'(v) > maxv) begin
			r = CFG_W'(maxv);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/rpr_mem.sv */
// ----------------------------------------------------------------------------
// rpr_mem
// Prefix store: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module rpr_mem import rpr_pkg::*; #(
	parameter int DEPTH = MAX_ROWS_DEF * MAX_COLS_DEF,
	parameter int AW    = $clog2(MAX_ROWS_DEF * MAX_COLS_DEF)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [AW-1:0]     rd_hi_addr,
	input  logic [AW-1:0]     rd_lo_addr,
	output logic [DATA_W-1:0] rd_hi_data,
	output logic [DATA_W-1:0] rd_lo_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_hi_data <= mem[rd_hi_addr];
		rd_lo_data <= mem[rd_lo_addr];
	end

endmodule

/* hw/rtl/rpr_load.sv */
// ----------------------------------------------------------------------------
// rpr_load
// Row-major load sequencer: running row sum and store write generation.
// ----------------------------------------------------------------------------
module rpr_load import rpr_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int AW       = $clog2(MAX_ROWS_DEF * MAX_COLS_DEF)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              restart,
	input  logic              go,
	input  logic [DATA_W-1:0] element,
	input  rpr_size_t         size,
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output logic [DATA_W-1:0] wr_data
);

	logic [CFG_W-1:0]  row_q;
	logic [CFG_W-1:0]  col_q;
	logic [DATA_W-1:0] sum_q;
	logic              done_q;
	logic              outside;
	logic [CFG_W-1:0]  row_nxt;
	logic [CFG_W-1:0]  col_nxt;

	assign outside = (row_q >= size.rows) || (int'(col_q) >= MAX_COLS);
	assign row_nxt = row_q + CFG_W'(1);
	assign col_nxt = col_q + CFG_W'(1);

	assign wr_en   = go && !done_q && !outside;
	assign wr_data = (col_q == '0) ? element : sum_q + element;
	assign wr_addr = AW'(row_q) * AW'(MAX_COLS) + AW'(col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			sum_q  <= '0;
			done_q <= 1'b0;
		end else if (restart) begin
			row_q  <= '0;
			col_q  <= '0;
			sum_q  <= '0;
			done_q <= 1'b0;
		end else if (go && !done_q) begin
			if (outside) begin
				done_q <= 1'b1;
			end else begin
				sum_q <= wr_data;
				if (col_nxt >= size.cols) begin
					col_q <= '0;
					row_q <= row_nxt;
					if (row_nxt >= size.rows) begin
						done_q <= 1'b1;
					end
				end else begin
					col_q <= col_nxt;
				end
			end
		end
	end

endmodule

/* hw/rtl/rpr_query.sv */
// ----------------------------------------------------------------------------
// rpr_query
// Rectangle query sequencer: walks the rows, reads two prefixes per row,
// accumulates the differences and holds the result register.
// ----------------------------------------------------------------------------
module rpr_query import rpr_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int AW       = $clog2(MAX_ROWS_DEF * MAX_COLS_DEF)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [COORD_W-1:0] row_first,
	input  logic [COORD_W-1:0] col_first,
	input  logic [COORD_W-1:0] row_last,
	input  logic [COORD_W-1:0] col_last,
	input  rpr_size_t          size,
	output logic [AW-1:0]      rd_hi_addr,
	output logic [AW-1:0]      rd_lo_addr,
	input  logic [DATA_W-1:0]  rd_hi_data,
	input  logic [DATA_W-1:0]  rd_lo_data,
	output logic               busy,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [DATA_W-1:0]  rect_sum,
	output logic               status
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]         state_q;
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] row_last_q;
	logic [COORD_W-1:0] col_first_q;
	logic [COORD_W-1:0] col_last_q;
	logic               vld_s1;
	logic [DATA_W-1:0]  acc_q;
	logic               err_q;
	logic               res_valid_q;
	logic [DATA_W-1:0]  res_sum_q;
	logic               res_status_q;
	logic               range_err;
	logic [AW-1:0]      row_base;
	logic [DATA_W-1:0]  lo_val;

	assign range_err = (CFG_W'(row_first) >= size.rows) || (CFG_W'(row_last) >= size.rows) ||
		(CFG_W'(col_first) >= size.cols) || (CFG_W'(col_last) >= size.cols);

	assign row_base   = AW'(row_q) * AW'(MAX_COLS);
	assign rd_hi_addr = row_base + AW'(col_last_q);
	assign rd_lo_addr = row_base + AW'(col_first_q) - AW'(1);
	assign lo_val     = (col_first_q == '0) ? '0 : rd_lo_data;

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = res_valid_q;
	assign rect_sum     = res_sum_q;
	assign status       = res_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vld_s1      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_RUN);
			if (state_q == ST_DONE && (!res_valid_q || result_ready)) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						if (range_err || (row_first > row_last)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (row_q == row_last_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_valid_q || result_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && go) begin
			row_q       <= row_first;
			row_last_q  <= row_last;
			col_first_q <= col_first;
			col_last_q  <= col_last;
			acc_q       <= '0;
			err_q       <= range_err ? STATUS_RANGE : STATUS_OK;
		end else begin
			if (state_q == ST_RUN && row_q != row_last_q) begin
				row_q <= row_q + COORD_W'(1);
			end
			if (vld_s1) begin
				acc_q <= acc_q + (rd_hi_data - lo_val);
			end
		end
		if (state_q == ST_DONE && (!res_valid_q || result_ready)) begin
			res_sum_q    <= acc_q;
			res_status_q <= err_q;
		end
	end

endmodule

/* hw/rtl/row_prefix_rectangle_sum_unit.sv */
// ----------------------------------------------------------------------------
// row_prefix_rectangle_sum_unit
// Row-wise prefix sum store with inclusive rectangle sum queries.
// ----------------------------------------------------------------------------
// Loads are accepted back to back while no query is busy; each turns an
// element into its row prefix sum and writes it to a MAX_ROWS*MAX_COLS word
// store with one write and two registered read ports. A query walks the
// rectangle one row per cycle through those two read ports and keeps the
// input held off through RUN, DRAIN and DONE until the result is registered;
// a query with a coordinate out of range or with reversed rows goes from
// IDLE straight to DONE. While a result waits in the output register the
// next item is accepted; a later query only finishes once it is taken.
// The store has no reset: query only entries that loads have written.
// ----------------------------------------------------------------------------
module row_prefix_rectangle_sum_unit import rpr_pkg::*; #(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wr_data,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic                 func,
	input  logic [DATA_W-1:0]    element,
	input  logic [COORD_W-1:0]   row_first,
	input  logic [COORD_W-1:0]   col_first,
	input  logic [COORD_W-1:0]   row_last,
	input  logic [COORD_W-1:0]   col_last,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [DATA_W-1:0]    rect_sum,
	output logic                 status
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CFG_W-1:0]  num_rows_q;
	logic [CFG_W-1:0]  num_cols_q;
	rpr_size_t         size;
	logic              restart;
	logic              accept;
	logic              busy;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic [AW-1:0]     rd_hi_addr;
	logic [AW-1:0]     rd_lo_addr;
	logic [DATA_W-1:0] rd_hi_data;
	logic [DATA_W-1:0] rd_lo_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= NUM_ROWS_RST;
			num_cols_q <= NUM_COLS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_NUM_ROWS: num_rows_q <= cfg_wr_data;
				CFG_NUM_COLS: num_cols_q <= cfg_wr_data;
				default: begin
				end
			endcase
		end
	end

	assign restart    = cfg_wr_en && (cfg_index == CFG_NUM_ROWS || cfg_index == CFG_NUM_COLS);
	assign size.rows  = eff_size(num_rows_q, MAX_ROWS);
	assign size.cols  = eff_size(num_cols_q, MAX_COLS);
	assign item_ready = !busy;
	assign accept     = item_valid && item_ready;

	rpr_load #(
		.MAX_COLS (MAX_COLS),
		.AW       (AW)
	) u_load (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.go      (accept && func == FUNC_LOAD),
		.element (element),
		.size    (size),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	rpr_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk        (clk),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_hi_addr (rd_hi_addr),
		.rd_lo_addr (rd_lo_addr),
		.rd_hi_data (rd_hi_data),
		.rd_lo_data (rd_lo_data)
	);

	rpr_query #(
		.MAX_COLS (MAX_COLS),
		.AW       (AW)
	) u_query (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (accept && func == FUNC_QUERY),
		.row_first    (row_first),
		.col_first    (col_first),
		.row_last     (row_last),
		.col_last     (col_last),
		.size         (size),
		.rd_hi_addr   (rd_hi_addr),
		.rd_lo_addr   (rd_lo_addr),
		.rd_hi_data   (rd_hi_data),
		.rd_lo_data   (rd_lo_data),
		.busy         (busy),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.rect_sum     (rect_sum),
		.status       (status)
	);

endmodule

/* tb/row_prefix_rectangle_sum_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_prefix_rectangle_sum_unit_tb
// Self-checking bench for the row prefix rectangle sum unit.
// ----------------------------------------------------------------------------
// A short table of directed loads, queries and size writes comes first. Then
// random phases follow, one per matrix size, including the clamped extremes.
// Each phase streams row-major loads with queries mixed in. Queries only
// touch stored prefixes that loads have written. A local prefix store
// predicts every rectangle sum. Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module row_prefix_rectangle_sum_unit_tb;
	import rpr_pkg::*;

	localparam int ROWS_MAX = MAX_ROWS_DEF;
	localparam int COLS_MAX = MAX_COLS_DEF;
	localparam int N_PHASES = 10;
	localparam int DIR_N    = 28;

	typedef enum logic {STEP_CFG, STEP_ITEM} step_kind_t;

	typedef struct {
		step_kind_t           kind;
		logic [CFG_IDX_W-1:0] cfg_idx;
		logic [CFG_W-1:0]     cfg_val;
		logic                 func;
		logic [DATA_W-1:0]    element;
		logic [COORD_W-1:0]   rf;
		logic [COORD_W-1:0]   cf;
		logic [COORD_W-1:0]   rl;
		logic [COORD_W-1:0]   cl;
		bit                   typed;
		logic [DATA_W-1:0]    t_sum;
		logic                 t_status;
	} dir_step_t;

	typedef struct {
		logic [DATA_W-1:0] sum;
		logic              status;
	} rect_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wr_data;
	logic                 item_valid;
	logic                 item_ready;
	logic                 func;
	logic [DATA_W-1:0]    element;
	logic [COORD_W-1:0]   row_first;
	logic [COORD_W-1:0]   col_first;
	logic [COORD_W-1:0]   row_last;
	logic [COORD_W-1:0]   col_last;
	logic                 result_valid;
	logic                 result_ready;
	logic [DATA_W-1:0]    rect_sum;
	logic                 status;

	// local copy of the block state
	logic [DATA_W-1:0] prefix_mem [ROWS_MAX*COLS_MAX];
	bit                prefix_set [ROWS_MAX*COLS_MAX];
	logic [CFG_W-1:0]  cfg_rows;
	logic [CFG_W-1:0]  cfg_cols;
	int                ld_row;
	int                ld_col;
	logic [DATA_W-1:0] run_sum;
	bit                ld_done;

	rect_result_t rect_sums_due [$];

	int n_err;
	int n_loads;
	int n_queries;
	int n_range;
	int n_checked;
	int max_walk;
	bit src_burst;

	dir_step_t dir_steps [DIR_N] = '{
		// rows reversed right after reset
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_QUERY, 32'd0,
			6'd5, 6'd0, 6'd4, 6'd0, 1'b1, 32'd0, STATUS_OK},
		'{STEP_CFG, CFG_NUM_ROWS, 7'd2, FUNC_LOAD, 32'd0,
			6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, STATUS_OK},
		'{STEP_CFG, CFG_NUM_COLS, 7'd3, FUNC_LOAD, 32'd0,
			6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, STATUS_OK},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_LOAD, 32'h7fffffff,
			6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, STATUS_OK},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_LOAD, 32'd1,
			6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, STATUS_OK},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_LOAD, 32'h80000000,
			6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, STATUS_OK},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_LOAD, 32'hffffffff,
			6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, STATUS_OK},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_LOAD, 32'd5,
			6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, STATUS_OK},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_LOAD, 32'hffffffff,
			6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, STATUS_OK},
		// matrix full, load dropped
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_LOAD, 32'd123,
			6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, STATUS_OK},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_QUERY, 32'd0,
			6'd0, 6'd0, 6'd1, 6'd2, 1'b0, 32'd0, STATUS_OK},
		// columns reversed
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_QUERY, 32'd0,
			6'd0, 6'd2, 6'd1, 6'd0, 1'b0, 32'd0, STATUS_OK},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_QUERY, 32'd0,
			6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, STATUS_OK},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_QUERY, 32'd0,
			6'd0, 6'd0, 6'd2, 6'd0, 1'b1, 32'd0, STATUS_RANGE},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_QUERY, 32'd0,
			6'd0, 6'd0, 6'd0, 6'd3, 1'b1, 32'd0, STATUS_RANGE},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_QUERY, 32'd0,
			6'd63, 6'd63, 6'd63, 6'd63, 1'b1, 32'd0, STATUS_RANGE},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_QUERY, 32'd0,
			6'd1, 6'd0, 6'd0, 6'd2, 1'b1, 32'd0, STATUS_OK},
		// zero rows counts as one, reload row 0
		'{STEP_CFG, CFG_NUM_ROWS, 7'd0, FUNC_LOAD, 32'd0,
			6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, STATUS_OK},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_LOAD, 32'd10,
			6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, STATUS_OK},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_LOAD, 32'd20,
			6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, STATUS_OK},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_LOAD, 32'd30,
			6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, STATUS_OK},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_LOAD, 32'd40,
			6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, STATUS_OK},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_QUERY, 32'd0,
			6'd0, 6'd1, 6'd0, 6'd2, 1'b0, 32'd0, STATUS_OK},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_QUERY, 32'd0,
			6'd1, 6'd0, 6'd1, 6'd0, 1'b1, 32'd0, STATUS_RANGE},
		// columns above the maximum clamp to it
		'{STEP_CFG, CFG_NUM_COLS, 7'd127, FUNC_LOAD, 32'd0,
			6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, STATUS_OK},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_LOAD, 32'd9,
			6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, STATUS_OK},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_QUERY, 32'd0,
			6'd0, 6'd0, 6'd0, 6'd0, 1'b0, 32'd0, STATUS_OK},
		'{STEP_ITEM, CFG_NUM_ROWS, 7'd0, FUNC_QUERY, 32'd0,
			6'd0, 6'd0, 6'd0, 6'd2, 1'b0, 32'd0, STATUS_OK}
	};

	row_prefix_rectangle_sum_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.func        (func),
		.element     (element),
		.row_first   (row_first),
		.col_first   (col_first),
		.row_last    (row_last),
		.col_last    (col_last),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.rect_sum    (rect_sum),
		.status      (status)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int eff_dim(logic [CFG_W-1:0] raw, int maxv);
		if (raw == '0) begin
			return 1;
		end
		if (int'(raw) > maxv) begin
			return maxv;
		end
		return int'(raw);
	endfunction

	// stall length: mostly short, now and then long
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [DATA_W-1:0] pick_element();
		case ($urandom_range(0, 19))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'hffffffff;
			3: return 32'd0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord(int lo, int hi);
		return COORD_W'($urandom_range(lo, hi));
	endfunction

	function automatic void restart_load();
		ld_row  = 0;
		ld_col  = 0;
		run_sum = '0;
		ld_done = 1'b0;
	endfunction

	function automatic void prefix_load(logic [DATA_W-1:0] v);
		int rows;
		int cols;
		rows = eff_dim(cfg_rows, ROWS_MAX);
		cols = eff_dim(cfg_cols, COLS_MAX);
		if (ld_done) begin
			return;
		end
		if (ld_row >= rows || ld_col >= COLS_MAX) begin
			ld_done = 1'b1;
			return;
		end
		if (ld_col == 0) begin
			run_sum = '0;
		end
		run_sum = run_sum + v;
		prefix_mem[ld_row*COLS_MAX + ld_col] = run_sum;
		prefix_set[ld_row*COLS_MAX + ld_col] = 1'b1;
		ld_col++;
		if (ld_col >= cols) begin
			ld_col = 0;
			ld_row++;
			if (ld_row >= rows) begin
				ld_done = 1'b1;
			end
		end
	endfunction

	function automatic rect_result_t rect_query(int rf, int cf, int rl, int cl);
		rect_result_t res;
		int rows;
		int cols;
		logic [DATA_W-1:0] lo;
		rows = eff_dim(cfg_rows, ROWS_MAX);
		cols = eff_dim(cfg_cols, COLS_MAX);
		res.sum = '0;
		res.status = STATUS_OK;
		if (rf >= rows || rl >= rows || cf >= cols || cl >= cols) begin
			res.status = STATUS_RANGE;
			return res;
		end
		for (int r = rf; r <= rl; r++) begin
			lo = (cf != 0) ? prefix_mem[r*COLS_MAX + cf - 1] : '0;
			res.sum = res.sum + (prefix_mem[r*COLS_MAX + cl] - lo);
		end
		return res;
	endfunction

	// true when an in-range query touches only written prefixes
	function automatic bit reads_written(int rf, int cf, int rl, int cl);
		for (int r = rf; r <= rl; r++) begin
			if (!prefix_set[r*COLS_MAX + cl]) begin
				return 1'b0;
			end
			if (cf != 0 && !prefix_set[r*COLS_MAX + cf - 1]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	task automatic build_query(output logic [COORD_W-1:0] rf, output logic [COORD_W-1:0] cf,
			output logic [COORD_W-1:0] rl, output logic [COORD_W-1:0] cl);
		int rows;
		int cols;
		int p;
		int a;
		int b;
		bit found;
		rows = eff_dim(cfg_rows, ROWS_MAX);
		cols = eff_dim(cfg_cols, COLS_MAX);
		p = $urandom_range(0, 99);
		rf = pick_coord(0, 63);
		cf = pick_coord(0, 63);
		rl = pick_coord(0, 63);
		cl = pick_coord(0, 63);
		if (p < 10) begin
			// one coordinate past the size, or reversed rows at the maximum size
			if (rows < ROWS_MAX && (cols == COLS_MAX || $urandom_range(0, 1))) begin
				if ($urandom_range(0, 1)) begin
					rf = pick_coord(rows, 63);
				end else begin
					rl = pick_coord(rows, 63);
				end
			end else if (cols < COLS_MAX) begin
				if ($urandom_range(0, 1)) begin
					cf = pick_coord(cols, 63);
				end else begin
					cl = pick_coord(cols, 63);
				end
			end else begin
				rf = pick_coord(1, 63);
				rl = pick_coord(0, int'(rf) - 1);
			end
		end else if (p < 16 && rows > 1) begin
			rl = pick_coord(0, rows - 2);
			rf = pick_coord(int'(rl) + 1, rows - 1);
			cf = pick_coord(0, cols - 1);
			cl = pick_coord(0, cols - 1);
		end else if (ld_row > 0 && (ld_col == 0 || $urandom_range(0, 1))) begin
			a = $urandom_range(0, ld_row - 1);
			b = $urandom_range(0, ld_row - 1);
			if ($urandom_range(0, 9) == 0) begin
				a = 0;
				b = ld_row - 1;
			end
			rf = COORD_W'((a < b) ? a : b);
			rl = COORD_W'((a < b) ? b : a);
			a = $urandom_range(0, cols - 1);
			b = $urandom_range(0, cols - 1);
			if ($urandom_range(0, 4) != 0 && a > b) begin
				cf = COORD_W'(b);
				cl = COORD_W'(a);
			end else begin
				cf = COORD_W'(a);
				cl = COORD_W'(b);
			end
		end else if (ld_col > 0) begin
			rf = COORD_W'(ld_row);
			rl = COORD_W'(ld_row);
			cf = pick_coord(0, ld_col - 1);
			cl = pick_coord(0, ld_col - 1);
		end else begin
			found = 1'b0;
			for (int t = 0; t < 20 && !found; t++) begin
				rf = pick_coord(0, rows - 1);
				rl = pick_coord(int'(rf), rows - 1);
				cf = pick_coord(0, cols - 1);
				cl = pick_coord(0, cols - 1);
				found = reads_written(int'(rf), int'(cf), int'(rl), int'(cl));
			end
			if (!found) begin
				rf = pick_coord(1, 63);
				rl = pick_coord(0, int'(rf) - 1);
			end
		end
	endtask

	// drives one transaction at a falling edge and waits for it to be taken
	task automatic push_item(logic f, logic [DATA_W-1:0] elem, logic [COORD_W-1:0] rf,
			logic [COORD_W-1:0] cf, logic [COORD_W-1:0] rl, logic [COORD_W-1:0] cl,
			bit typed, logic [DATA_W-1:0] t_sum, logic t_status);
		rect_result_t res;
		int gap;
		item_valid <= 1'b1;
		func       <= f;
		element    <= elem;
		row_first  <= rf;
		col_first  <= cf;
		row_last   <= rl;
		col_last   <= cl;
		@(posedge clk);
		while (!item_ready) begin
			@(posedge clk);
		end
		if (f == FUNC_LOAD) begin
			n_loads++;
			prefix_load(elem);
		end else begin
			n_queries++;
			res = rect_query(int'(rf), int'(cf), int'(rl), int'(cl));
			if (res.status == STATUS_RANGE) begin
				n_range++;
			end else if (rf <= rl && int'(rl) - int'(rf) + 1 > max_walk) begin
				max_walk = int'(rl) - int'(rf) + 1;
			end
			if (typed) begin
				res.sum = t_sum;
				res.status = t_status;
			end
			rect_sums_due.push_back(res);
		end
		@(negedge clk);
		gap = (src_burst || $urandom_range(0, 99) < 65) ? 0 : pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// block idle: no sum outstanding and the last loads retired
	task automatic drain_sums();
		item_valid <= 1'b0;
		while (rect_sums_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_NUM_ROWS) begin
			cfg_rows = val;
		end else begin
			cfg_cols = val;
		end
		restart_load();
		@(negedge clk);
	endtask

	initial begin
		logic [CFG_W-1:0]   phase_rows [N_PHASES];
		logic [CFG_W-1:0]   phase_cols [N_PHASES];
		logic [COORD_W-1:0] qrf;
		logic [COORD_W-1:0] qcf;
		logic [COORD_W-1:0] qrl;
		logic [COORD_W-1:0] qcl;
		int budget;
		int counted;
		int cells;
		bit was_done;

		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_index   = CFG_NUM_ROWS;
		cfg_wr_data = '0;
		item_valid  = 1'b0;
		func        = FUNC_LOAD;
		element     = '0;
		row_first   = '0;
		col_first   = '0;
		row_last    = '0;
		col_last    = '0;
		n_err       = 0;
		n_loads     = 0;
		n_queries   = 0;
		n_range     = 0;
		n_checked   = 0;
		max_walk    = 0;
		src_burst   = 1'b0;
		cfg_rows    = NUM_ROWS_RST;
		cfg_cols    = NUM_COLS_RST;
		restart_load();
		for (int i = 0; i < ROWS_MAX*COLS_MAX; i++) begin
			prefix_mem[i] = '0;
			prefix_set[i] = 1'b0;
		end

		phase_rows = '{7'd64, 7'd1, 7'd0, 7'd5, 7'd64, 7'd100, 7'd0, 7'd0, 7'd3, 7'd4};
		phase_cols = '{7'd1, 7'd64, 7'd127, 7'd7, 7'd64, 7'd3, 7'd0, 7'd0, 7'd2, 7'd4};
		for (int i = 6; i < 8; i++) begin
			phase_rows[i] = CFG_W'($urandom_range(1, 8));
			phase_cols[i] = CFG_W'($urandom_range(1, 8));
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			if (dir_steps[i].kind == STEP_CFG) begin
				drain_sums();
				write_reg(dir_steps[i].cfg_idx, dir_steps[i].cfg_val);
			end else begin
				push_item(dir_steps[i].func, dir_steps[i].element, dir_steps[i].rf,
					dir_steps[i].cf, dir_steps[i].rl, dir_steps[i].cl,
					dir_steps[i].typed, dir_steps[i].t_sum, dir_steps[i].t_status);
			end
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain_sums();
			write_reg(CFG_NUM_ROWS, phase_rows[ph]);
			write_reg(CFG_NUM_COLS, phase_cols[ph]);
			cells = eff_dim(cfg_rows, ROWS_MAX) * eff_dim(cfg_cols, COLS_MAX);
			budget = (cells <= 64) ? cells + 20 : 45;
			counted = 0;
			while (counted < budget) begin
				if ($urandom_range(0, 39) == 0) begin
					src_burst = !src_burst;
				end
				was_done = ld_done;
				if ($urandom_range(0, 99) < (ld_done ? 6 : 70)) begin
					push_item(FUNC_LOAD, pick_element(), pick_coord(0, 63),
						pick_coord(0, 63), pick_coord(0, 63),
						pick_coord(0, 63), 1'b0, '0, STATUS_OK);
					if (!was_done) begin
						counted++;
					end
				end else begin
					build_query(qrf, qcf, qrl, qcl);
					push_item(FUNC_QUERY, $urandom, qrf, qcf, qrl, qcl, 1'b0, '0, STATUS_OK);
					counted++;
				end
			end
		end

		item_valid <= 1'b0;
		for (int w = 0; w < 5000 && rect_sums_due.size() != 0; w++) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (rect_sums_due.size() != 0) begin
			$error("%0d rectangle sums never arrived", rect_sums_due.size());
			n_err += rect_sums_due.size();
		end

		$display("covered %0d loads and %0d queries (%0d out of range), %0d sums checked",
			n_loads, n_queries, n_range, n_checked);
		$display("%0d matrix sizes incl. clamped ones, longest row walk %0d rows",
			N_PHASES + 4, max_walk);
		if (n_err == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		int hold;
		logic rdy;
		hold = 0;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else begin
				case ($urandom_range(0, 19))
					0: begin
						rdy = 1'b1;
						hold = $urandom_range(100, 300);
					end
					1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: begin
						rdy = 1'b1;
						hold = $urandom_range(0, 15);
					end
					default: begin
						rdy = 1'b0;
						hold = pick_gap() - 1;
					end
				endcase
				result_ready <= rdy;
			end
		end
	end

	always @(posedge clk) begin
		rect_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (rect_sums_due.size() == 0) begin
				$error("unexpected result transaction: rect_sum %h status %0d", rect_sum, status);
				n_err++;
			end else begin
				want = rect_sums_due.pop_front();
				n_checked++;
				if (rect_sum !== want.sum) begin
					$error("rect_sum mismatch: expected %h, actual %h", want.sum, rect_sum);
					n_err++;
				end
				if (status !== want.status) begin
					$error("status mismatch: expected %0d, actual %0d", want.status, status);
					n_err++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
